[design/mrtb_pkg.sv]
// ---------------------------------------------------------------------------
// mrtb_pkg
// Shared types and constants for the multi-rate tick bank.
// ---------------------------------------------------------------------------
package mrtb_pkg;

    localparam int NUM_INTERVALS = 3600;
    localparam int ADDR_W        = $clog2(NUM_INTERVALS);
    localparam int IVL_W         = $clog2(NUM_INTERVALS + 1);

    localparam int CMD_W      = 2;
    localparam int IN_IVL_W   = 12;
    localparam int TICK_W     = 32;
    localparam int ROLL_W     = 32;
    localparam int USERS_W    = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 88;

    localparam logic [TICK_W-1:0]  TICK_LIMIT = 32'd4294966271;
    localparam logic [ROLL_W-1:0]  ROLL_MAX   = 32'hFFFF_FFFF;
    localparam logic [USERS_W-1:0] USERS_MAX  = 16'hFFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_ATTACH = 2'd1,
        CMD_DETACH = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD,
        S_SWEEP,
        S_PUT
    } t_state;

    // One memory word per interval. The remainder field holds the current
    // phase modulo the interval, so the sweep never has to divide.
    typedef struct packed {
        logic [ADDR_W-1:0]  rem;
        logic [USERS_W-1:0] users;
        logic [ROLL_W-1:0]  roll;
        logic [TICK_W-1:0]  tick;
    } t_entry;

    typedef struct packed {
        logic               err;
        logic [USERS_W-1:0] users;
        logic [ROLL_W-1:0]  roll;
        logic [TICK_W-1:0]  tick;
    } t_result;

endpackage

[design/mrtb_ram.sv]
// ---------------------------------------------------------------------------
// mrtb_ram
// Entry memory: one write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module mrtb_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [mrtb_pkg::ADDR_W-1:0] i_waddr,
    input  mrtb_pkg::t_entry            i_wdata,
    input  logic                        i_re,
    input  logic [mrtb_pkg::ADDR_W-1:0] i_raddr,
    output mrtb_pkg::t_entry            o_rdata
);
    import mrtb_pkg::*;

    t_entry r_mem [NUM_INTERVALS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/multi_rate_tick_bank.sv]
// ---------------------------------------------------------------------------
// multi_rate_tick_bank
// Bank of per-interval tick counters held in one entry memory.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Ports             Contents (lowest bit first)
//  s_axis   in         i_s_axis_*        command[1:0], interval[13:2], zero pad
//  m_axis   out        o_m_axis_*        tick_value[31:0], roll_value[63:32],
//                                        users[79:64], error[80], zero pad
//
// A base tick sweeps every interval entry through a read-modify-write
// pipeline at one entry per cycle, reading the next entry while the
// last one read is written back, then passes through S_PUT to the output.
// Attach, detach and read pass through S_UPD and S_PUT; a bad interval
// goes straight to S_PUT. After reset a clearing pass writes zero to
// every entry, and no item is accepted until it ends.
// One item is in work at a time; a finished result waits in the output
// register, and the next item is accepted while it waits.
// ---------------------------------------------------------------------------
module multi_rate_tick_bank (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // command[1:0], interval[13:2]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [87:0] o_m_axis_tdata    // tick, roll, users, error
);
    import mrtb_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_INTERVALS - 1);

    t_state                r_state, n_state;
    logic [ADDR_W-1:0]     r_addr, n_addr;
    logic [ADDR_W-1:0]     r_phase, n_phase;
    logic                  r_p_one, n_p_one;
    logic                  r_err, n_err;
    t_cmd                  r_cmd, n_cmd;
    t_result               r_res, n_res;
    logic                  r_ovalid, n_ovalid;
    t_result               r_odata, n_odata;

    // Memory port signals.
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    t_entry                mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    t_entry                mem_q;

    // Input decode.
    t_cmd                  in_cmd;
    logic [IN_IVL_W-1:0]   in_ivl;
    logic                  in_bad;
    logic [ADDR_W-1:0]     in_idx;
    logic                  accept;
    logic                  out_free;

    // Sweep datapath.
    logic [IVL_W-1:0]      swp_x;
    logic [IVL_W-1:0]      swp_rem_inc;
    logic [ADDR_W-1:0]     swp_rem;
    logic                  swp_hit;
    logic [TICK_W-1:0]     swp_tick_inc;
    logic                  swp_sat;
    t_entry                swp_entry;

    // Single-entry update datapath.
    t_entry                upd_entry;
    logic                  upd_err;

    mrtb_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    assign in_cmd   = t_cmd'(i_s_axis_tdata[1:0]);
    assign in_ivl   = i_s_axis_tdata[13:2];
    assign in_bad   = (in_ivl == '0) || ({1'b0, in_ivl} > 13'(NUM_INTERVALS));
    assign in_idx   = ADDR_W'(in_ivl - 12'd1);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_ovalid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {7'd0, r_odata.err, r_odata.users,
                              r_odata.roll, r_odata.tick};

    // Sweep step for the entry whose data has just come out of memory.
    // The stored remainder follows the phase; when the phase restarts at
    // one, every remainder is set to one modulo its interval.
    always_comb begin
        swp_x       = IVL_W'(r_addr) + IVL_W'(1);
        swp_rem_inc = IVL_W'(mem_q.rem) + IVL_W'(1);
        if (r_p_one) begin
            swp_rem = (r_addr == '0) ? '0 : ADDR_W'(1);
        end else begin
            swp_rem = (swp_rem_inc == swp_x) ? '0 : swp_rem_inc[ADDR_W-1:0];
        end
        // Interval one counts on every base tick, users or not.
        swp_hit      = (r_addr == '0) || ((swp_rem == '0) && (mem_q.users != '0));
        swp_tick_inc = mem_q.tick + TICK_W'(1);
        swp_sat      = 1'b0;
        swp_entry    = mem_q;
        swp_entry.rem = swp_rem;
        if (swp_hit) begin
            if (swp_tick_inc >= TICK_LIMIT) begin
                swp_entry.tick = '0;
                if (mem_q.roll == ROLL_MAX) begin
                    swp_sat = 1'b1;
                end else begin
                    swp_entry.roll = mem_q.roll + ROLL_W'(1);
                end
            end else begin
                swp_entry.tick = swp_tick_inc;
            end
        end
    end

    // Attach and detach on one entry. Reaching zero users clears the tick.
    always_comb begin
        upd_entry = mem_q;
        upd_err   = 1'b0;
        case (r_cmd)
            CMD_ATTACH: begin
                if (mem_q.users == USERS_MAX) begin
                    upd_err = 1'b1;
                end else begin
                    upd_entry.users = mem_q.users + USERS_W'(1);
                end
            end
            CMD_DETACH: begin
                if (mem_q.users == '0) begin
                    upd_err = 1'b1;
                end else begin
                    upd_entry.users = mem_q.users - USERS_W'(1);
                    if (mem_q.users == USERS_W'(1)) begin
                        upd_entry.tick = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (in_cmd == CMD_TICK) begin
                        n_state = S_SWEEP;
                    end else if (in_bad) begin
                        n_state = S_PUT;
                    end else begin
                        n_state = S_UPD;
                    end
                end
            end
            S_UPD: begin
                n_state = S_PUT;
            end
            S_SWEEP: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = swp_entry;
        mem_re    = 1'b0;
        mem_raddr = r_addr + ADDR_W'(1);
        n_addr    = r_addr;
        n_phase   = r_phase;
        n_p_one   = r_p_one;
        n_err     = r_err;
        n_cmd     = r_cmd;
        n_res     = r_res;
        n_ovalid  = r_ovalid && !i_m_axis_tready;
        n_odata   = r_odata;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                n_addr    = (r_addr == LAST_ADDR) ? '0 : r_addr + ADDR_W'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    n_cmd = in_cmd;
                    if (in_cmd == CMD_TICK) begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        n_addr    = '0;
                        n_err     = 1'b0;
                        n_p_one   = (r_phase == '0);
                    end else if (in_bad) begin
                        n_res     = '0;
                        n_res.err = 1'b1;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = in_idx;
                        n_addr    = in_idx;
                    end
                end
            end
            S_UPD: begin
                mem_we      = 1'b1;
                mem_wdata   = upd_entry;
                n_res.tick  = upd_entry.tick;
                n_res.roll  = upd_entry.roll;
                n_res.users = upd_entry.users;
                n_res.err   = upd_err;
            end
            S_SWEEP: begin
                mem_we = 1'b1;
                n_err  = r_err || swp_sat;
                if (r_addr == '0) begin
                    n_res.tick  = swp_entry.tick;
                    n_res.roll  = swp_entry.roll;
                    n_res.users = swp_entry.users;
                end
                if (r_addr != LAST_ADDR) begin
                    mem_re = 1'b1;
                    n_addr = r_addr + ADDR_W'(1);
                end else begin
                    n_res.err = r_err || swp_sat;
                    if (IVL_W'(r_phase) + IVL_W'(1) == IVL_W'(NUM_INTERVALS)) begin
                        n_phase = '0;
                    end else begin
                        n_phase = r_phase + ADDR_W'(1);
                    end
                end
            end
            S_PUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_res;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_phase  <= '0;
            r_p_one  <= 1'b0;
            r_err    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_phase  <= n_phase;
            r_p_one  <= n_p_one;
            r_err    <= n_err;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_res   <= n_res;
        r_odata <= n_odata;
    end

endmodule

[verif/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-rate tick bank. It drives commands into
// the item stream, keeps its own model of every interval's tick, wrap and
// user counts, and compares each returned report field by field.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrtb_pkg::*;

    // A base tick sweeps the whole entry memory, and so does the clearing
    // pass after reset. No legal gap between handshakes comes anywhere near
    // the watchdog limit.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 120;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;   // command[1:0], interval[13:2]
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;          // tick, roll, users, error

    multi_rate_tick_bank uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bench copy of the bank state. Entry i belongs to interval i+1.
    bit [TICK_W-1:0]  tick_mem [NUM_INTERVALS];
    bit [ROLL_W-1:0]  roll_mem [NUM_INTERVALS];
    bit [USERS_W-1:0] user_mem [NUM_INTERVALS];
    int unsigned      phase_now = 0;

    t_result expected_reports [$];
    int      fail_count   = 0;
    int      quiet_cycles = 0;
    int      stall_left   = 0;
    bit      idling       = 1'b1;

    // Gap lengths: mostly none, often short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Counts one tick on an entry. Returns 1 when the wrap count was already
    // pinned at its maximum, in which case it stays there.
    function automatic bit advance_counter(input int idx);
        bit pinned;
        pinned = 1'b0;
        tick_mem[idx] = tick_mem[idx] + TICK_W'(1);
        if (tick_mem[idx] >= TICK_LIMIT) begin
            tick_mem[idx] = '0;
            if (roll_mem[idx] == ROLL_MAX) pinned = 1'b1;
            else roll_mem[idx] = roll_mem[idx] + ROLL_W'(1);
        end
        return pinned;
    endfunction

    // Applies one command to the bench state and returns the report the
    // bank must produce for it.
    function automatic t_result apply_command(input t_cmd cmd,
                                              input logic [IN_IVL_W-1:0] ivl);
        t_result     r;
        int unsigned p;
        int          x;
        int          idx;
        r = '0;
        if (cmd == CMD_TICK) begin
            p = (phase_now & 32'hFFF) + 1;
            r.err = advance_counter(0);
            // Interval one counts regardless; the others only with users.
            for (x = 2; x <= NUM_INTERVALS; x++) begin
                if ((p % x) == 0 && user_mem[x-1] != 0) begin
                    if (advance_counter(x - 1)) r.err = 1'b1;
                end
            end
            phase_now = (p >= NUM_INTERVALS) ? 0 : (p & 32'hFFF);
            idx = 0;
        end else begin
            if (ivl == 0 || ivl > NUM_INTERVALS) begin
                r.err = 1'b1;
                return r;
            end
            idx = ivl - 1;
            if (cmd == CMD_ATTACH) begin
                if (user_mem[idx] == USERS_MAX) r.err = 1'b1;
                else user_mem[idx] = user_mem[idx] + USERS_W'(1);
            end else if (cmd == CMD_DETACH) begin
                if (user_mem[idx] == 0) begin
                    r.err = 1'b1;
                end else begin
                    user_mem[idx] = user_mem[idx] - USERS_W'(1);
                    if (user_mem[idx] == 0) tick_mem[idx] = '0;
                end
            end
        end
        r.tick  = tick_mem[idx];
        r.roll  = roll_mem[idx];
        r.users = user_mem[idx];
        return r;
    endfunction

    // Presents one item, waits for the handshake, and records what the bank
    // must answer. Valid is only changed on falling edges.
    task automatic send_item(input t_cmd cmd, input logic [IN_IVL_W-1:0] ivl);
        int gap;
        gap = idling ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, ivl, cmd};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_reports.push_back(apply_command(cmd, ivl));
    endtask

    // Holds the sender off until every outstanding report has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_reads_after_reset();
        send_item(CMD_READ, 12'd1);
        send_item(CMD_READ, 12'd3600);
        send_item(CMD_READ, 12'd0);       // below the range
        send_item(CMD_READ, 12'd3601);    // just above the range
        send_item(CMD_READ, 12'd4095);    // every interval bit set
        drain_results();
    endtask

    task automatic test_attach_detach_tick();
        send_item(CMD_DETACH, 12'd5);     // nobody attached yet
        send_item(CMD_ATTACH, 12'd2);
        send_item(CMD_ATTACH, 12'd3);
        send_item(CMD_ATTACH, 12'd3);
        send_item(CMD_ATTACH, 12'd3600);
        send_item(CMD_ATTACH, 12'd1);
        repeat (4) send_item(CMD_TICK, 12'd0);
        send_item(CMD_READ, 12'd2);
        send_item(CMD_READ, 12'd3);
        send_item(CMD_DETACH, 12'd3);     // one user left, tick kept
        send_item(CMD_DETACH, 12'd3);     // last user leaves, tick cleared
        send_item(CMD_DETACH, 12'd3);
        send_item(CMD_DETACH, 12'd3600);  // the top interval may be detached
        send_item(CMD_DETACH, 12'd1);     // clears interval one's tick
        send_item(CMD_TICK, 12'd4095);    // interval field is ignored here
        send_item(CMD_ATTACH, 12'd0);
        send_item(CMD_ATTACH, 12'd4095);
        send_item(CMD_DETACH, 12'd3601);
        send_item(CMD_READ, 12'd2048);
        drain_results();
    endtask

    task automatic test_random_traffic();
        int                  n;
        int                  pick;
        t_cmd                cmd;
        logic [IN_IVL_W-1:0] ivl;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            // Alternate stretches with and without idling on both sides.
            if (n % 30 == 0) idling = ($urandom_range(0, 3) != 0);
            if (n == RANDOM_ITEMS / 2) drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 30)      cmd = CMD_TICK;
            else if (pick < 60) cmd = CMD_ATTACH;
            else if (pick < 80) cmd = CMD_DETACH;
            else                cmd = CMD_READ;
            // Small intervals divide the early phases, so they see ticks.
            pick = $urandom_range(0, 99);
            if (pick < 70)      ivl = IN_IVL_W'($urandom_range(1, 64));
            else if (pick < 85) ivl = IN_IVL_W'($urandom_range(1, NUM_INTERVALS));
            else if (pick < 90) ivl = 12'd0;
            else                ivl = IN_IVL_W'($urandom_range(NUM_INTERVALS + 1, 4095));
            send_item(cmd, ivl);
        end
        idling = 1'b1;
        drain_results();
    endtask

    // Receiver side: ready stalls of random length, or always ready.
    always @(negedge i_clk) begin
        if (!idling) begin
            stall_left = 0;
            i_m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    task automatic report_field(input string label, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, label, want, got);
        end
    endtask

    // Each accepted report is held against the oldest expectation.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_result'(o_m_axis_tdata[80:0]);
            if (expected_reports.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected report, expected none, got %h",
                         $time, o_m_axis_tdata);
            end else begin
                want = expected_reports.pop_front();
                report_field("tick_value", want.tick, got.tick);
                report_field("roll_value", want.roll, got.roll);
                report_field("users", {16'd0, want.users}, {16'd0, got.users});
                report_field("error", {31'd0, want.err}, {31'd0, got.err});
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("multi_rate_tick_bank verification failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reads_after_reset();
        test_attach_detach_tick();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (expected_reports.size() != 0) fail_count++;
        if (fail_count == 0)
            $display("multi_rate_tick_bank verification clean");
        else
            $display("multi_rate_tick_bank verification failed");
        $finish;
    end

endmodule
